// ----- src/ppt_pkg.sv -----
// Shared types and constants for the pulse period tachometer.
// No dependencies; every other file imports this package.
package ppt_pkg;

	// Input item codes
	localparam logic OP_PULSE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Configuration register indexes
	localparam logic REG_RATE_NUM    = 1'b0;
	localparam logic REG_STALE_LIMIT = 1'b1;

	localparam int CFG_DATA_W  = 32;
	localparam int STALE_W     = 8;
	localparam int RPM_W       = 23;
	// Dividing by avg * 512 equals dividing the numerator shifted right by 9 by avg
	localparam int AVG_SHIFT   = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [STALE_W-1:0]    STALE_CAP       = 8'd254;
	localparam logic [STALE_W-1:0]    STALE_RESET     = 8'd4;
	localparam logic [CFG_DATA_W-1:0] RATE_NUM_RESET  = 32'd663540000;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_AVG,
		BK_RPM_GO,
		BK_RPM_WAIT,
		BK_OUT
	} ppt_back_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ppt_div_stat_t;

endpackage

// ----- src/ppt_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on ppt_pkg for the status struct.
module ppt_div import ppt_pkg::*; #(
	parameter int W = 23
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output ppt_div_stat_t stat,
	output logic [W-1:0] quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0] shifted;
	logic [W:0] diff;
	logic       ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ----- src/ppt_fifo.sv -----
// Short command queue between the front and back parts.
// Depends on ppt_pkg for its depth.
module ppt_fifo import ppt_pkg::*; #(
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          full,
	output logic          empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DW-1:0]    mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full    = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_ptr_q];

endmodule

// ----- src/ppt_front.sv -----
// Front part: accepts items, tracks pulse period and staleness, queues ticks.
// Depends on ppt_pkg for item codes and the staleness cap.
module ppt_front import ppt_pkg::*; #(
	parameter int STAMP_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [STAMP_BITS-1:0] timestamp,
	input  logic [STALE_W-1:0]    stale_limit,
	input  logic                  queue_full,
	output logic                  push,
	output logic                  push_stale,
	output logic [STAMP_BITS-1:0] push_period
);

	logic [STAMP_BITS-1:0] last_stamp_q;
	logic [STAMP_BITS-1:0] period_q;
	logic [STALE_W-1:0]    stale_q;
	logic                  accept;

	assign in_stall    = queue_full;
	assign accept      = in_valid && !queue_full;
	assign push        = accept && (opcode == OP_TICK);
	assign push_stale  = stale_q >= stale_limit;
	assign push_period = period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			period_q     <= '0;
			stale_q      <= '0;
		end else if (accept) begin
			if (opcode == OP_PULSE) begin
				period_q     <= timestamp - last_stamp_q;
				last_stamp_q <= timestamp;
				stale_q      <= '0;
			end else if (stale_q < STALE_CAP) begin
				stale_q <= stale_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/ppt_back.sv -----
// Back part: period window, running sum, reciprocal average, one divider pass, result register.
// Depends on ppt_pkg for the state type, divider status and widths.
module ppt_back import ppt_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int STAMP_BITS = 16,
	parameter int SUM_W      = 20,
	parameter int DIV_W      = 23
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  queue_empty,
	input  logic                  queue_stale,
	input  logic [STAMP_BITS-1:0] queue_period,
	output logic                  pop,
	input  logic [CFG_DATA_W-1:0] rate_numerator,
	output logic                  div_start,
	output logic [DIV_W-1:0]      div_dividend,
	output logic [DIV_W-1:0]      div_divisor,
	input  ppt_div_stat_t         div_stat,
	input  logic [DIV_W-1:0]      div_quotient,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RPM_W-1:0]      speed_rpm
);

	localparam logic [STAMP_BITS-1:0] STAMP_ONES = {STAMP_BITS{1'b1}};
	localparam logic [SUM_W-1:0]      FILL_SUM   = SUM_W'(STAMP_ONES) * SUM_W'(WINDOW_LEN);

	// Average by reciprocal multiplication: exact for every sum below 2^SUM_W
	localparam int AVG_RSHIFT = SUM_W + $clog2(WINDOW_LEN);
	localparam int RECIP_W    = AVG_RSHIFT + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(((64'd1 << AVG_RSHIFT) +
		64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	ppt_back_state_t state_q, state_d;

	logic [STAMP_BITS-1:0] win_q [WINDOW_LEN];
	logic [SUM_W-1:0]      sum_q;
	logic [RPM_W-1:0]      rpm_q;
	logic                  out_valid_q;
	logic [RPM_W-1:0]      speed_q;
	logic                  out_free;
	logic                  load_out;
	logic                  avg_zero;
	logic [PROD_W-1:0]     avg_prod;
	logic [STAMP_BITS-1:0] avg;

	assign avg_prod = PROD_W'(sum_q) * PROD_W'(AVG_RECIP);
	assign avg      = avg_prod[AVG_RSHIFT +: STAMP_BITS];
	assign out_free = !out_valid_q || !out_stall;
	assign avg_zero = avg == '0;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!queue_empty) begin
					state_d = queue_stale ? BK_OUT : BK_AVG;
				end
			end
			BK_AVG:      state_d = avg_zero ? BK_OUT : BK_RPM_GO;
			BK_RPM_GO:   state_d = BK_RPM_WAIT;
			BK_RPM_WAIT: begin
				if (div_stat.done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default:     state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop          = 1'b0;
		div_start    = 1'b0;
		load_out     = 1'b0;
		div_dividend = DIV_W'(rate_numerator >> AVG_SHIFT);
		div_divisor  = DIV_W'(avg);
		case (state_q)
			BK_IDLE:   pop = !queue_empty;
			BK_RPM_GO: div_start = 1'b1;
			BK_OUT:    load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			sum_q       <= FILL_SUM;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= STAMP_ONES;
			end
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (queue_stale) begin
					sum_q <= FILL_SUM;
					for (int i = 0; i < WINDOW_LEN; i++) begin
						win_q[i] <= STAMP_ONES;
					end
				end else begin
					// drop the oldest entry from the running sum, add the newest
					sum_q <= sum_q - SUM_W'(win_q[WINDOW_LEN-1]) + SUM_W'(queue_period);
					for (int i = WINDOW_LEN - 1; i > 0; i--) begin
						win_q[i] <= win_q[i-1];
					end
					win_q[0] <= queue_period;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && queue_stale) begin
			rpm_q <= '0;
		end else if (state_q == BK_AVG && avg_zero) begin
			rpm_q <= '0;
		end else if (state_q == BK_RPM_WAIT && div_stat.done) begin
			rpm_q <= div_quotient[RPM_W-1:0];
		end
		if (load_out) begin
			speed_q <= rpm_q;
		end
	end

	assign out_valid = out_valid_q;
	assign speed_rpm = speed_q;

endmodule

// ----- src/pulse_period_tachometer.sv -----
// Pulse period tachometer: averages pulse periods over a window and reports speed in rpm.
// Depends on ppt_pkg, ppt_front, ppt_fifo, ppt_div and ppt_back.
//
// A pulse item (opcode 0) never produces a result; it records the modular period since
// the previous timestamp and clears the staleness count. An evaluate tick (opcode 1) is
// queued by the front part and handled by the back part: the window shift and running-sum
// update happen as the tick is popped, the window average comes from a reciprocal
// multiplication, then a restoring divider of DIV_W bits (DIV_W being the wider of 23 and
// the window-sum width) producing one quotient bit per cycle divides the numerator by the
// average times 512, and the result is loaded into the output register. A stale tick and a
// zero average both report zero without using the divider. A two-entry queue lets pulses
// and ticks keep arriving while the back part divides or while a result waits in the
// output register. The window resets to all ones; there is no clearing pass.
module pulse_period_tachometer import ppt_pkg::*; #(
	parameter int WINDOW_LEN = 10,
	parameter int STAMP_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [STAMP_BITS-1:0] timestamp,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RPM_W-1:0]      speed_rpm,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SUM_W = STAMP_BITS + $clog2(WINDOW_LEN + 1);
	localparam int DIV_W = (SUM_W > RPM_W) ? SUM_W : RPM_W;
	localparam int QW    = STAMP_BITS + 1;

	logic [CFG_DATA_W-1:0] rate_num_q;
	logic [STALE_W-1:0]    stale_limit_q;

	logic                  push;
	logic                  push_stale;
	logic [STAMP_BITS-1:0] push_period;
	logic                  pop;
	logic [QW-1:0]         pop_data;
	logic                  queue_full;
	logic                  queue_empty;

	logic                  div_start;
	logic [DIV_W-1:0]      div_dividend;
	logic [DIV_W-1:0]      div_divisor;
	ppt_div_stat_t         div_stat;
	logic [DIV_W-1:0]      div_quotient;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_num_q    <= RATE_NUM_RESET;
			stale_limit_q <= STALE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_RATE_NUM) begin
				rate_num_q <= cfg_data;
			end else if (cfg_index == REG_STALE_LIMIT) begin
				stale_limit_q <= cfg_data[STALE_W-1:0];
			end
		end
	end

	ppt_front #(
		.STAMP_BITS(STAMP_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.timestamp  (timestamp),
		.stale_limit(stale_limit_q),
		.queue_full (queue_full),
		.push       (push),
		.push_stale (push_stale),
		.push_period(push_period)
	);

	ppt_fifo #(
		.DW(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_stale, push_period}),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	ppt_div #(
		.W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.stat    (div_stat),
		.quotient(div_quotient)
	);

	ppt_back #(
		.WINDOW_LEN(WINDOW_LEN),
		.STAMP_BITS(STAMP_BITS),
		.SUM_W     (SUM_W),
		.DIV_W     (DIV_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.queue_stale   (pop_data[QW-1]),
		.queue_period  (pop_data[STAMP_BITS-1:0]),
		.pop           (pop),
		.rate_numerator(rate_num_q),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_stat      (div_stat),
		.div_quotient  (div_quotient),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.speed_rpm     (speed_rpm)
	);

	// The divider is never restarted mid-division
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// A finished division was running in the previous cycle
	a_div_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> $past(div_stat.busy))
		else $error("divider done without a running division");

	// The back part pops only when the queue holds an entry
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("queue popped while empty");

	// A division start is never directly followed by a queue pop
	a_start_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !pop)
		else $error("queue popped during a division");

endmodule

// ----- tb/pulse_period_tachometer_tb.sv -----
// Self-checking testbench for pulse_period_tachometer: pulse and tick items with random
// gaps and output stalls, speed checked against an in-bench model of the averaging window.
// Depends on ppt_pkg and the pulse_period_tachometer RTL.
module pulse_period_tachometer_tb;
	import ppt_pkg::*;

	localparam int WIN_LEN         = 10;
	localparam int STAMP_W         = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 200;
	localparam int IDLE_LIMIT      = 4000;
	localparam int MAX_REPORTS     = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  opcode = OP_PULSE;
	logic [STAMP_W-1:0]    timestamp = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [RPM_W-1:0]      speed_rpm;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = REG_RATE_NUM;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pulse_period_tachometer #(
		.WINDOW_LEN(WIN_LEN),
		.STAMP_BITS(STAMP_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.timestamp(timestamp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.speed_rpm(speed_rpm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Tachometer model state and configuration
	logic [STAMP_W-1:0]    m_last_stamp;
	logic [STAMP_W-1:0]    m_period;
	logic [STAMP_W-1:0]    m_window [WIN_LEN];
	logic [STALE_W-1:0]    m_stale;
	logic [CFG_DATA_W-1:0] m_rate;
	logic [STALE_W-1:0]    m_stale_lim;

	logic [RPM_W-1:0] rpm_expected_q [$];

	int  n_items   = 0;
	int  n_results = 0;
	int  n_writes  = 0;
	int  n_fail    = 0;
	bit  src_jitter  = 1'b1;
	bit  sink_jitter = 1'b1;
	bit  sink_hold_req = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// Update the model with one accepted item; a tick queues the speed it yields
	task automatic advance_tach(input logic op, input logic [STAMP_W-1:0] ts);
		logic [31:0] sum;
		logic [31:0] avg;
		logic [63:0] divisor;
		logic [63:0] quo;
		int i;
		sum = '0;
		quo = '0;
		if (op == OP_PULSE) begin
			m_period = ts - m_last_stamp;
			m_last_stamp = ts;
			m_stale = '0;
		end else begin
			if (m_stale < m_stale_lim) begin
				for (i = WIN_LEN - 1; i > 0; i--)
					m_window[i] = m_window[i-1];
				m_window[0] = m_period;
				for (i = 0; i < WIN_LEN; i++)
					sum = sum + 32'(m_window[i]);
				avg = sum / WIN_LEN;
				divisor = {32'd0, avg} * 64'd512;
				if (divisor != 0)
					quo = {32'd0, m_rate} / divisor;
			end else begin
				for (i = 0; i < WIN_LEN; i++)
					m_window[i] = '1;
			end
			if (m_stale < STALE_CAP)
				m_stale = m_stale + 8'd1;
			rpm_expected_q.push_back(quo[RPM_W-1:0]);
		end
	endtask

	task automatic send_item(input logic op, input logic [STAMP_W-1:0] ts);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		timestamp <= ts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_tach(op, ts);
		n_items++;
		gap = src_jitter ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (rpm_expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Pulses give no result, so let any queued work finish before touching registers
	task automatic wait_quiet();
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_RATE_NUM)
			m_rate = data;
		else
			m_stale_lim = data[STALE_W-1:0];
		n_writes++;
	endtask

	task automatic note_mismatch(input string what, input logic [RPM_W-1:0] want,
			input logic [RPM_W-1:0] got);
		n_fail++;
		if (n_fail <= MAX_REPORTS)
			$display("mismatch (%s) at result %0d: expected speed_rpm %0d, got %0d",
				what, n_results, want, got);
	endtask

	// Compare each accepted result with the oldest expected speed
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (rpm_expected_q.size() == 0)
				note_mismatch("no result expected", '0, speed_rpm);
			else if (speed_rpm !== rpm_expected_q[0])
				note_mismatch("speed_rpm", rpm_expected_q[0], speed_rpm);
			if (rpm_expected_q.size() != 0)
				void'(rpm_expected_q.pop_front());
			n_results++;
		end
	end

	// Receiver: random stalls, or one long hold-off on request
	initial begin : sink_proc
		int n;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				n = sink_jitter ? pick_gap() : 0;
				out_stall <= (n > 0);
				if (n > 1)
					repeat (n - 1) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// Reset window, equal and wrapping stamps, going stale, zero average
	task automatic test_directed();
		int i;
		send_item(OP_TICK, 16'hFFFF);
		send_item(OP_PULSE, 16'h0000);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_PULSE, 16'hFFFF);
		send_item(OP_PULSE, 16'h0000);
		for (i = 0; i < 6; i++)
			send_item(OP_TICK, 16'h5A5A);
		write_reg(REG_STALE_LIMIT, 32'd254);
		send_item(OP_PULSE, 16'h1234);
		send_item(OP_PULSE, 16'h1234);
		for (i = 0; i < WIN_LEN; i++)
			send_item(OP_TICK, 16'hA5A5);
	endtask

	// Numerator and stale-limit extremes, counter saturation
	task automatic test_extremes();
		int i;
		write_reg(REG_RATE_NUM, 32'hFFFF_FFFF);
		for (i = 0; i < 12; i++) begin
			send_item(OP_PULSE, m_last_stamp + 16'd1);
			send_item(OP_TICK, STAMP_W'($urandom));
		end
		send_item(OP_PULSE, m_last_stamp + 16'hFFFF);
		for (i = 0; i < 3; i++)
			send_item(OP_TICK, STAMP_W'($urandom));
		write_reg(REG_RATE_NUM, 32'd1);
		send_item(OP_TICK, STAMP_W'($urandom));
		send_item(OP_TICK, STAMP_W'($urandom));
		write_reg(REG_STALE_LIMIT, 32'd0);
		send_item(OP_PULSE, m_last_stamp + 16'd777);
		for (i = 0; i < 3; i++)
			send_item(OP_TICK, STAMP_W'($urandom));
		write_reg(REG_RATE_NUM, RATE_NUM_RESET);
		write_reg(REG_STALE_LIMIT, 32'd255);
		send_item(OP_PULSE, m_last_stamp + 16'd1500);
		for (i = 0; i < 260; i++)
			send_item(OP_TICK, STAMP_W'($urandom));
		write_reg(REG_STALE_LIMIT, 32'd1);
		send_item(OP_PULSE, m_last_stamp + 16'd900);
		send_item(OP_TICK, STAMP_W'($urandom));
		send_item(OP_TICK, STAMP_W'($urandom));
	endtask

	// Mostly a pulse followed by a few ticks, with some random items mixed in
	task automatic run_random_phase(input int n_target, input int noise_pct);
		int sent;
		int k;
		int period;
		int base_p;
		sent = 0;
		case ($urandom_range(0, 2))
			0: base_p = $urandom_range(1, 40);
			1: base_p = $urandom_range(200, 4000);
			default: base_p = $urandom_range(8000, 60000);
		endcase
		while (sent < n_target) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send_item(1'($urandom_range(0, 1)), STAMP_W'($urandom));
				sent++;
			end else begin
				period = base_p + $urandom_range(0, base_p / 8 + 1);
				send_item(OP_PULSE, m_last_stamp + period[STAMP_W-1:0]);
				sent++;
				if ($urandom_range(0, 9) == 0)
					k = $urandom_range(1, 40);
				else
					k = $urandom_range(1, 3);
				repeat (k) begin
					send_item(OP_TICK, STAMP_W'($urandom));
					sent++;
				end
			end
		end
	endtask

	task automatic test_random();
		run_random_phase(230, 10);
		write_reg(REG_RATE_NUM, $urandom);
		write_reg(REG_STALE_LIMIT, $urandom_range(1, 254));
		// stretch with no idling on either side
		src_jitter = 1'b0;
		sink_jitter = 1'b0;
		run_random_phase(200, 10);
		src_jitter = 1'b1;
		sink_jitter = 1'b1;
		write_reg(REG_RATE_NUM, 32'hFFFF_FFFF);
		write_reg(REG_STALE_LIMIT, 32'd1);
		run_random_phase(220, 15);
		write_reg(REG_RATE_NUM, $urandom_range(1, 1 << 20));
		write_reg(REG_STALE_LIMIT, 32'd254);
		run_random_phase(220, 10);
		write_reg(REG_RATE_NUM, $urandom);
		write_reg(REG_STALE_LIMIT, 32'd8);
		run_random_phase(230, 20);
		write_reg(REG_RATE_NUM, $urandom);
		write_reg(REG_STALE_LIMIT, 32'd255);
		run_random_phase(200, 10);
	endtask

	// Fill the block behind a long output hold-off, then drain before going on
	task automatic test_backpressure();
		int i;
		write_reg(REG_RATE_NUM, RATE_NUM_RESET);
		write_reg(REG_STALE_LIMIT, CFG_DATA_W'(STALE_RESET));
		src_jitter = 1'b0;
		sink_hold_req = 1'b1;
		for (i = 0; i < 40; i++) begin
			if (i % 2 == 0)
				send_item(OP_PULSE, m_last_stamp + 16'd2500);
			else
				send_item(OP_TICK, STAMP_W'($urandom));
		end
		wait_drain();
		src_jitter = 1'b1;
		for (i = 0; i < 30; i++)
			send_item(1'($urandom_range(0, 1)), STAMP_W'($urandom));
	endtask

	initial begin : main
		int i;
		m_last_stamp = '0;
		m_period = '0;
		m_stale = '0;
		m_rate = RATE_NUM_RESET;
		m_stale_lim = STALE_RESET;
		for (i = 0; i < WIN_LEN; i++)
			m_window[i] = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_random();
		test_backpressure();
		wait_quiet();
		$display("run covered %0d items, %0d speed results, %0d register writes",
			n_items, n_results, n_writes);
		$display("stale limits 0..255, numerators 1..2^32-1, output hold-off; %0d mismatches",
			n_fail);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
